FILE: sv/fac_pkg.sv
package fac_pkg;

  // Field widths
  localparam int unsigned ElemW  = 32;
  localparam int unsigned PlaneW = 3;
  localparam int unsigned CompW  = ElemW + 1;          // row3 +/- row k
  localparam int unsigned ProdW  = CompW + ElemW;      // exact product
  localparam int unsigned AccW   = ProdW + 2;          // three products plus d
  localparam int unsigned DShift = 16;                 // Q16.16 to Q32.32

  // Opcodes
  localparam logic OpWrite = 1'b0;
  localparam logic OpBox   = 1'b1;

  // Matrix store read request, two ports
  typedef struct packed {
    logic       en;
    logic [3:0] addr_a;
    logic [3:0] addr_b;
  } mat_rd_t;

  // Matrix store write request
  typedef struct packed {
    logic             en;
    logic [3:0]       addr;
    logic [ElemW-1:0] data;
  } mat_wr_t;

  // Multiply-accumulate operation
  typedef struct packed {
    logic                    start;
    logic                    load;   // load d << 16 instead of adding n * v
    logic signed [CompW-1:0] n;
    logic signed [ElemW-1:0] v;
  } mac_op_t;

endpackage

FILE: sv/fac_matrix_store.sv
module fac_matrix_store
  import fac_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mat_wr_t          wr_i,
  input  mat_rd_t          rd_i,
  output logic [ElemW-1:0] rd_a_o,
  output logic [ElemW-1:0] rd_b_o
);

  logic [ElemW-1:0] mem_q [16];
  logic [15:0]      valid_q;
  logic [ElemW-1:0] rd_a_q;
  logic [ElemW-1:0] rd_b_q;

  // Mark written entries; unwritten ones read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  // Store element
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered reads on both ports
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_a_q <= valid_q[rd_i.addr_a] ? mem_q[rd_i.addr_a] : '0;
      rd_b_q <= valid_q[rd_i.addr_b] ? mem_q[rd_i.addr_b] : '0;
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

FILE: sv/fac_mac.sv
module fac_mac
  import fac_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  mac_op_t op_i,
  output logic    neg_o,
  output logic    busy_o
);

  logic                    pipe_q;
  logic                    load_q;
  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;

  // Form product, or align d to the product's binary point
  always_comb begin
    if (op_i.load) begin
      prod_d = ProdW'(op_i.n) <<< DShift;
    end else begin
      prod_d = op_i.n * op_i.v;
    end
  end

  // Track the product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= 1'b0;
    end else begin
      pipe_q <= op_i.start;
    end
  end

  // Register product
  always_ff @(posedge clk_i) begin
    if (op_i.start) begin
      prod_q <= prod_d;
      load_q <= op_i.load;
    end
  end

  // Accumulate
  always_ff @(posedge clk_i) begin
    if (pipe_q) begin
      if (load_q) begin
        acc_q <= AccW'(prod_q);
      end else begin
        acc_q <= acc_q + AccW'(prod_q);
      end
    end
  end

  assign neg_o  = acc_q[AccW-1];
  assign busy_o = pipe_q;

endmodule

FILE: sv/frustum_aabb_cull.sv
// Frustum culling of axis-aligned boxes against a stored 4x4 view-projection
// matrix. A write item (opcode 0) stores one Q16.16 element and gives no
// result. A box item (opcode 1) gives one outside flag: planes r3+r0,
// r3-r0, r3+r1, r3-r1, r3+r2, r3-r2 are tested in that order up to
// plane_count (saturated to PLANE_SLOTS), using the p-vertex picked by the
// signs of each normal, with exact arithmetic and no normalisation. Testing
// stops at the first plane that rejects. Each of the four plane components
// goes through one read of the two-port matrix store, one add or subtract,
// and one pass of the single shared 33x32 multiply-accumulate unit, and a
// final check step tests the sign of the 67-bit sum. The block takes no
// item while a box is in progress; a finished result waits in the output
// register while the next item is accepted.
module frustum_aabb_cull
  import fac_pkg::*;
#(
  parameter int unsigned PLANE_SLOTS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [PlaneW-1:0] cfg_data_i,
  // input items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [1:0]        row_index_i,
  input  logic [1:0]        col_index_i,
  input  logic [ElemW-1:0]  element_value_i,
  input  logic [ElemW-1:0]  min_x_i,
  input  logic [ElemW-1:0]  min_y_i,
  input  logic [ElemW-1:0]  min_z_i,
  input  logic [ElemW-1:0]  max_x_i,
  input  logic [ElemW-1:0]  max_y_i,
  input  logic [ElemW-1:0]  max_z_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              outside_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FORM,
    S_MUL,
    S_ACC,
    S_CHECK,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic [1:0]              comp_q;       // 0: d, 1..3: x, y, z
  logic [PlaneW-1:0]       plane_q;
  logic [PlaneW-1:0]       count_q;
  logic [PlaneW-1:0]       plane_count_q;
  logic [PlaneW-1:0]       count_sat;
  logic                    result_q;
  logic                    out_valid_q;
  logic                    outside_q;
  logic signed [CompW-1:0] n_q;
  logic signed [ElemW-1:0] bmin_q [3];
  logic signed [ElemW-1:0] bmax_q [3];

  logic                    in_acc;
  logic [1:0]              col;
  logic [1:0]              axis;
  logic [ElemW-1:0]        rd_a;
  logic [ElemW-1:0]        rd_b;
  logic signed [CompW-1:0] n_d;
  logic                    mac_neg;
  logic                    mac_busy;
  mat_wr_t                 mat_wr;
  mat_rd_t                 mat_rd;
  mac_op_t                 mac_op;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign outside_o   = outside_q;

  // Hold plane count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= PlaneW'(6);
    end else if (cfg_valid_i) begin
      plane_count_q <= cfg_data_i;
    end
  end

  assign count_sat = (plane_count_q > PlaneW'(PLANE_SLOTS)) ? PlaneW'(PLANE_SLOTS)
                                                             : plane_count_q;

  // Column of the current component; d sits in column 3
  assign col  = (comp_q == 2'd0) ? 2'd3 : comp_q - 2'd1;
  assign axis = comp_q - 2'd1;

  // Matrix store requests
  always_comb begin
    mat_wr.en     = in_acc && (opcode_i == OpWrite);
    mat_wr.addr   = {row_index_i, col_index_i};
    mat_wr.data   = element_value_i;
    mat_rd.en     = (state_q == S_READ);
    mat_rd.addr_a = {2'd3, col};
    mat_rd.addr_b = {plane_q[2:1], col};
  end

  fac_matrix_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (mat_wr),
    .rd_i   (mat_rd),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // Plane component: row3 plus or minus the selected row
  always_comb begin
    if (plane_q[0]) begin
      n_d = CompW'($signed(rd_a)) - CompW'($signed(rd_b));
    end else begin
      n_d = CompW'($signed(rd_a)) + CompW'($signed(rd_b));
    end
  end

  // Feed the shared unit: d first, then normal times p-vertex coordinate
  always_comb begin
    mac_op.start = (state_q == S_MUL);
    mac_op.load  = (comp_q == 2'd0);
    mac_op.n     = n_q;
    if (comp_q == 2'd0) begin
      mac_op.v = '0;
    end else if (n_q[CompW-1]) begin
      mac_op.v = bmin_q[axis];
    end else begin
      mac_op.v = bmax_q[axis];
    end
  end

  fac_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .neg_o  (mac_neg),
    .busy_o (mac_busy)
  );

  // Capture box corners
  always_ff @(posedge clk_i) begin
    if (in_acc && (opcode_i == OpBox)) begin
      bmin_q[0] <= min_x_i;
      bmin_q[1] <= min_y_i;
      bmin_q[2] <= min_z_i;
      bmax_q[0] <= max_x_i;
      bmax_q[1] <= max_y_i;
      bmax_q[2] <= max_z_i;
    end
  end

  // Register plane component
  always_ff @(posedge clk_i) begin
    if (state_q == S_FORM) begin
      n_q <= n_d;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      comp_q      <= '0;
      plane_q     <= '0;
      count_q     <= '0;
      result_q    <= 1'b0;
      out_valid_q <= 1'b0;
      outside_q   <= 1'b0;
    end else begin
      // drop a taken result unless a finished box refills the register
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && (opcode_i == OpBox)) begin
            comp_q   <= '0;
            plane_q  <= '0;
            count_q  <= count_sat;
            result_q <= 1'b0;
            state_q  <= (count_sat == '0) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          state_q <= S_FORM;
        end
        S_FORM: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          comp_q <= comp_q + 2'd1;
          if (comp_q == 2'd3) begin
            state_q <= S_CHECK;
          end else begin
            state_q <= S_READ;
          end
        end
        S_CHECK: begin
          if (mac_neg) begin
            result_q <= 1'b1;
            state_q  <= S_DONE;
          end else if (plane_q + PlaneW'(1) == count_q) begin
            state_q <= S_DONE;
          end else begin
            plane_q <= plane_q + PlaneW'(1);
            state_q <= S_READ;
          end
        end
        S_DONE: begin
          // hand over once the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            outside_q   <= result_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Plane index stays below the saturated count while a box is tested
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_DONE) |->
      (plane_q < count_q && count_q <= PlaneW'(PLANE_SLOTS)))
    else $error("plane index out of range");

  // Sign is checked only once the last accumulation has landed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> !mac_busy)
    else $error("sign checked while accumulator busy");

  // A result appears only when a box finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result without finished box");

  // A write item leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OpWrite) |=> (state_q == S_IDLE))
    else $error("write item started processing");

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import fac_pkg::*;

  localparam int unsigned Slots      = 6;
  localparam int unsigned HoldOff    = 120;     // outlasts the longest box
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned ChunkItems = 190;

  localparam logic [ElemW-1:0] QOne      = 32'h0001_0000;
  localparam logic [ElemW-1:0] QMinusOne = 32'hffff_0000;
  localparam logic [ElemW-1:0] QHalf     = 32'h0000_8000;
  localparam logic [ElemW-1:0] QMinusHlf = 32'hffff_8000;
  localparam logic [ElemW-1:0] QMostNeg  = 32'h8000_0000;
  localparam logic [ElemW-1:0] QMostPos  = 32'h7fff_ffff;

  typedef struct packed {
    logic             op;
    logic [1:0]       row;
    logic [1:0]       col;
    logic [ElemW-1:0] elem;
    logic [ElemW-1:0] min_x;
    logic [ElemW-1:0] min_y;
    logic [ElemW-1:0] min_z;
    logic [ElemW-1:0] max_x;
    logic [ElemW-1:0] max_y;
    logic [ElemW-1:0] max_z;
  } cull_item_t;

  localparam int unsigned ItemW = $bits(cull_item_t);

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [PlaneW-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              opcode_i;
  logic [1:0]        row_index_i;
  logic [1:0]        col_index_i;
  logic [ElemW-1:0]  element_value_i;
  logic [ElemW-1:0]  min_x_i;
  logic [ElemW-1:0]  min_y_i;
  logic [ElemW-1:0]  min_z_i;
  logic [ElemW-1:0]  max_x_i;
  logic [ElemW-1:0]  max_y_i;
  logic [ElemW-1:0]  max_z_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              outside_o;

  // Mirror of the block's matrix and plane count
  logic signed [ElemW-1:0] mat_q [16];
  int unsigned             plane_cnt;

  logic        outside_q [$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  frustum_aabb_cull #(
    .PLANE_SLOTS(Slots)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .element_value_i(element_value_i),
    .min_x_i        (min_x_i),
    .min_y_i        (min_y_i),
    .min_z_i        (min_z_i),
    .max_x_i        (max_x_i),
    .max_y_i        (max_y_i),
    .max_z_i        (max_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .outside_o      (outside_o)
  );

  // Clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // Compare each result item with the oldest pending flag
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outside_q.size() == 0) begin
        report_mismatch($sformatf("result %0b with none pending", outside_o));
      end else begin
        want = outside_q.pop_front();
        if (outside_o !== want)
          report_mismatch($sformatf("outside expected %0b, got %0b", want, outside_o));
      end
    end
  end

  // Plane k component c: row 3 plus or minus row k/2, kept at 33 bits
  function automatic logic signed [CompW-1:0] plane_comp(int unsigned k, int unsigned c);
    logic signed [CompW-1:0] base;
    logic signed [CompW-1:0] other;
    base  = mat_q[12 + c];
    other = mat_q[(k / 2) * 4 + c];
    return (k % 2 == 1) ? base - other : base + other;
  endfunction

  // Exact p-vertex test of one box against the leading planes
  function automatic logic predict_outside(cull_item_t it);
    logic signed [ElemW-1:0] lo [3];
    logic signed [ElemW-1:0] hi [3];
    logic signed [CompW-1:0] n;
    logic signed [ElemW-1:0] v;
    logic signed [127:0]     acc;
    int unsigned             planes;
    lo[0] = it.min_x; lo[1] = it.min_y; lo[2] = it.min_z;
    hi[0] = it.max_x; hi[1] = it.max_y; hi[2] = it.max_z;
    planes = (plane_cnt > Slots) ? Slots : plane_cnt;
    for (int unsigned k = 0; k < planes; k++) begin
      acc = plane_comp(k, 3);
      acc = acc <<< DShift;
      for (int unsigned c = 0; c < 3; c++) begin
        n   = plane_comp(k, c);
        v   = n[CompW-1] ? lo[c] : hi[c];
        acc = acc + n * v;
      end
      if (acc[127]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic cull_item_t write_item(logic [1:0] row, logic [1:0] col,
                                            logic [ElemW-1:0] val);
    cull_item_t it;
    it      = ItemW'({$urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom});
    it.op   = OpWrite;
    it.row  = row;
    it.col  = col;
    it.elem = val;
    return it;
  endfunction

  function automatic cull_item_t box_item(logic [ElemW-1:0] mnx, logic [ElemW-1:0] mny,
                                          logic [ElemW-1:0] mnz, logic [ElemW-1:0] mxx,
                                          logic [ElemW-1:0] mxy, logic [ElemW-1:0] mxz);
    cull_item_t it;
    it       = ItemW'({$urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom});
    it.op    = OpBox;
    it.min_x = mnx; it.min_y = mny; it.min_z = mnz;
    it.max_x = mxx; it.max_y = mxy; it.max_z = mxz;
    return it;
  endfunction

  // Q16.16 word: often small values, sometimes zero, the extremes or any pattern
  function automatic logic [ElemW-1:0] rand_word();
    logic [ElemW-1:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0:       return QMostNeg;
      1:       return QMostPos;
      2:       return '0;
      3, 4, 5: return {{12{r[19]}}, r[19:0]};
      default: return r;
    endcase
  endfunction

  function automatic cull_item_t rand_item();
    logic [ElemW-1:0] a [3];
    logic [ElemW-1:0] b [3];
    logic [ElemW-1:0] t;
    if ($urandom_range(99) < 30)
      return write_item(2'($urandom), 2'($urandom), rand_word());
    for (int i = 0; i < 3; i++) begin
      a[i] = rand_word();
      b[i] = rand_word();
      // keep most boxes well formed
      if ($urandom_range(99) < 85 && $signed(a[i]) > $signed(b[i])) begin
        t = a[i]; a[i] = b[i]; b[i] = t;
      end
    end
    return box_item(a[0], a[1], a[2], b[0], b[1], b[2]);
  endfunction

  // Offer one item, hold it until taken, then update the mirror
  task automatic send_item(cull_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= it.op;
    row_index_i     <= it.row;
    col_index_i     <= it.col;
    element_value_i <= it.elem;
    min_x_i         <= it.min_x;
    min_y_i         <= it.min_y;
    min_z_i         <= it.min_z;
    max_x_i         <= it.max_x;
    max_y_i         <= it.max_y;
    max_z_i         <= it.max_z;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.op == OpBox) outside_q.push_back(predict_outside(it));
    else mat_q[{it.row, it.col}] = it.elem;
  endtask

  // Hold the sender until every pending result has come
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outside_q.size() != 0);
  endtask

  task automatic set_plane_count(int unsigned val);
    drain();
    repeat (HoldOff) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= PlaneW'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    plane_cnt = val & 7;
  endtask

  // Zero matrix: every normal is zero and d is zero, so nothing is culled
  task automatic test_after_reset();
    send_item(box_item(QMostNeg, QMostNeg, QMostNeg, QMostPos, QMostPos, QMostPos));
    send_item(box_item(QOne, QOne, QOne, QMinusOne, QMinusOne, QMinusOne));
  endtask

  // Identity matrix gives the cube -1..1 on every axis
  task automatic test_identity_frustum();
    for (int i = 0; i < 4; i++) send_item(write_item(2'(i), 2'(i), QOne));
    send_item(box_item(QMinusHlf, QMinusHlf, QMinusHlf, QHalf, QHalf, QHalf));
    send_item(box_item(32'h0002_0000, '0, '0, 32'h0003_0000, '0, '0));
    send_item(box_item('0, '0, 32'hfffd_0000, '0, '0, 32'hfffe_0000));
    send_item(box_item(32'hfffd_0000, QMinusHlf, QMinusHlf, 32'h0003_0000, QHalf, QHalf));
    // inverted box: corners taken as given
    send_item(box_item(32'h0003_0000, '0, '0, 32'hfffd_0000, '0, '0));
  endtask

  // Only the last plane rejects a box at z 2..3; counts above six saturate
  task automatic test_plane_limit();
    int unsigned counts [4] = '{5, 6, 7, 0};
    foreach (counts[i]) begin
      set_plane_count(counts[i]);
      send_item(box_item('0, '0, 32'h0002_0000, '0, '0, 32'h0003_0000));
    end
    set_plane_count(Slots);
  endtask

  // Zero normals with d below zero reject any box
  task automatic test_zero_normal();
    for (int i = 0; i < 3; i++) send_item(write_item(2'(i), 2'(i), '0));
    send_item(write_item(2'd3, 2'd3, QMinusOne));
    send_item(box_item(QMostPos, QMostPos, QMostPos, QMostNeg, QMostNeg, QMostNeg));
    set_plane_count(1);
    send_item(box_item('0, '0, '0, QOne, QOne, QOne));
  endtask

  // Extreme elements so that plane components need all 33 bits
  task automatic test_extremes();
    set_plane_count(Slots);
    send_item(write_item(2'd0, 2'd0, QMostNeg));
    send_item(write_item(2'd3, 2'd0, QMostPos));
    send_item(write_item(2'd0, 2'd3, QMostPos));
    send_item(write_item(2'd3, 2'd3, QMostNeg));
    send_item(box_item(QMostNeg, QMostNeg, QMostNeg, QMostPos, QMostPos, QMostPos));
    send_item(box_item(QMostPos, '0, '0, QMostPos, '0, '0));
    send_item(box_item(QMostNeg, QMostPos, QMostNeg, QMostNeg, QMostPos, QMostNeg));
  endtask

  // Random items in chunks, a fresh plane count before each chunk
  task automatic test_random(int unsigned snd_pct, int unsigned rcv_pct,
                             int unsigned cnt_a, int unsigned cnt_b, int unsigned cnt_c);
    int unsigned counts [3];
    counts = '{cnt_a, cnt_b, cnt_c};
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    foreach (counts[i]) begin
      set_plane_count(counts[i]);
      repeat (ChunkItems) send_item(rand_item());
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    opcode_i        <= OpWrite;
    row_index_i     <= '0;
    col_index_i     <= '0;
    element_value_i <= '0;
    min_x_i         <= '0;
    min_y_i         <= '0;
    min_z_i         <= '0;
    max_x_i         <= '0;
    max_y_i         <= '0;
    max_z_i         <= '0;
    out_ready_i     <= 1'b0;
    cycle_cnt       = 0;
    err_cnt         = 0;
    send_idle_pct   = 19;
    recv_idle_pct   = 65;
    plane_cnt       = Slots;
    foreach (mat_q[i]) mat_q[i] = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_identity_frustum();
    test_plane_limit();
    test_zero_normal();
    test_extremes();
    test_random(19, 65, 6, 0, 3);
    test_random(65, 19, 7, 1, 5);
    test_random(0, 0, 2, 4, 6);

    drain();
    repeat (HoldOff) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/fac_pkg.sv
sv/fac_matrix_store.sv
sv/fac_mac.sv
sv/frustum_aabb_cull.sv
tb/tb_top.sv
